// File: rtl/des_block_cipher_unit_assert.svh
// Assertion macros for the DES block cipher unit.
// Used by the top-level module; no other dependencies.
`ifndef DES_BLOCK_CIPHER_UNIT_ASSERT_SVH
`define DES_BLOCK_CIPHER_UNIT_ASSERT_SVH

// Assert that an antecedent implies a consequent on the next edge.
`define DES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Assert that an antecedent implies a consequent on the same edge.
`define DES_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/des_pkg.sv
// Package for the DES block cipher unit: FIPS 46-3 tables and the
// permutation, S-box, round-function and key-schedule helpers.
package des_pkg;

  localparam int NumRounds = 16;
  localparam int BlockW    = 64;
  localparam int HalfW     = 32;
  localparam int SubkeyW   = 48;
  localparam int CdW       = 56;
  localparam int HalfCdW   = 28;

  localparam logic ActEncrypt = 1'b0;
  localparam logic ActDecrypt = 1'b1;

  typedef logic [SubkeyW-1:0] subkey_t;
  typedef logic [BlockW-1:0]  block_t;
  typedef logic [HalfW-1:0]   half_t;

  typedef struct packed {
    logic   dec;
    half_t  l;
    half_t  r;
  } round_data_t;

  localparam byte unsigned TabIp [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

  localparam byte unsigned TabFp [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

  localparam byte unsigned TabE [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};

  localparam byte unsigned TabP [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};

  localparam byte unsigned TabPc1 [56] = '{
    57,49,41,33,25,17,9,  1,58,50,42,34,26,18,
    10,2,59,51,43,35,27,  19,11,3,60,52,44,36,
    63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29,  21,13,5,28,20,12,4};

  localparam byte unsigned TabPc2 [48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};

  localparam byte unsigned TabRot [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

  localparam byte unsigned TabS [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,3,5,6,11,0}};

  function automatic block_t perm_ip(block_t src);
    block_t o;
    for (int i = 0; i < BlockW; i++) o[BlockW-1-i] = src[BlockW - int'(TabIp[i])];
    return o;
  endfunction

  function automatic block_t perm_fp(block_t src);
    block_t o;
    for (int i = 0; i < BlockW; i++) o[BlockW-1-i] = src[BlockW - int'(TabFp[i])];
    return o;
  endfunction

  function automatic subkey_t perm_e(half_t src);
    subkey_t o;
    for (int i = 0; i < SubkeyW; i++) o[SubkeyW-1-i] = src[HalfW - int'(TabE[i])];
    return o;
  endfunction

  function automatic half_t perm_p(half_t src);
    half_t o;
    for (int i = 0; i < HalfW; i++) o[HalfW-1-i] = src[HalfW - int'(TabP[i])];
    return o;
  endfunction

  function automatic logic [CdW-1:0] perm_pc1(block_t src);
    logic [CdW-1:0] o;
    for (int i = 0; i < CdW; i++) o[CdW-1-i] = src[BlockW - int'(TabPc1[i])];
    return o;
  endfunction

  function automatic subkey_t perm_pc2(logic [CdW-1:0] src);
    subkey_t o;
    for (int i = 0; i < SubkeyW; i++) o[SubkeyW-1-i] = src[CdW - int'(TabPc2[i])];
    return o;
  endfunction

  function automatic half_t feistel(half_t r, subkey_t k);
    subkey_t x;
    half_t s;
    logic [5:0] six;
    x = perm_e(r) ^ k;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      six = x[SubkeyW-1-6*i -: 6];
      s[HalfW-1-4*i -: 4] = TabS[i][{six[5], six[0], six[4:1]}][3:0];
    end
    return perm_p(s);
  endfunction

  // Round keys for a key; the rotations are fixed wiring per round.
  function automatic subkey_t [NumRounds-1:0] key_schedule(block_t key);
    logic [CdW-1:0] cd;
    logic [HalfCdW-1:0] c, d;
    subkey_t [NumRounds-1:0] ks;
    cd = perm_pc1(key);
    c = cd[CdW-1:HalfCdW];
    d = cd[HalfCdW-1:0];
    for (int r = 0; r < NumRounds; r++) begin
      for (int j = 0; j < int'(TabRot[r]); j++) begin
        c = {c[HalfCdW-2:0], c[HalfCdW-1]};
        d = {d[HalfCdW-2:0], d[HalfCdW-1]};
      end
      ks[r] = perm_pc2({c, d});
    end
    return ks;
  endfunction

endpackage

// File: rtl/des_in_if.sv
// Input channel interface: action bit and 64-bit block.
// Depends on des_pkg.
interface des_in_if import des_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   action;
  block_t data_block;
  modport source (output valid, action, data_block, input ready);
  modport sink (input valid, action, data_block, output ready);
endinterface

// File: rtl/des_out_if.sv
// Result channel interface: 64-bit result block.
// Depends on des_pkg.
interface des_out_if import des_pkg::*; ();
  logic   valid;
  logic   ready;
  block_t result_block;
  modport source (output valid, result_block, input ready);
  modport sink (input valid, result_block, output ready);
endinterface

// File: rtl/des_key_sched.sv
// Registered round-key table for the DES unit.
// Depends on des_pkg.
module des_key_sched import des_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  block_t                  cfg_wdata,
  output subkey_t [NumRounds-1:0] round_keys
);
  subkey_t [NumRounds-1:0] keys_r, keys_nxt;

  // Round keys of the all-zero key are all zero.
  always_comb begin
    keys_nxt = keys_r;
    if (cfg_we) begin
      keys_nxt = key_schedule(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r <= '0;
    end else begin
      keys_r <= keys_nxt;
    end
  end

  assign round_keys = keys_r;
endmodule

// File: rtl/des_round.sv
// One pipelined Feistel round stage with valid and stall control.
// Depends on des_pkg.
module des_round import des_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    advance,
  input  logic                    in_valid,
  input  round_data_t             in_data,
  input  subkey_t [NumRounds-1:0] round_keys,
  input  logic [3:0]              round_idx,
  output logic                    out_valid,
  output round_data_t             out_data
);
  logic        valid_r;
  round_data_t data_r, data_nxt;
  subkey_t     k;

  always_comb begin
    k = in_data.dec ? round_keys[4'(NumRounds-1) - round_idx] : round_keys[round_idx];
    data_nxt.dec = in_data.dec;
    data_nxt.l   = in_data.r;
    data_nxt.r   = in_data.l ^ feistel(in_data.r, k);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
endmodule

// File: rtl/des_block_cipher_unit.sv
// DES ECB block cipher unit. Accepts one block per clock unless stalled.
// Input permutation register, sixteen Feistel round stages and an output
// register. Throughput is set by the one-round-per-stage pipeline. The user
// must write the key through cfg_we/cfg_wdata only while no transaction is
// in flight (unenforced); round keys are ready in the cycle after the write.
// Depends on des_pkg, des_in_if, des_out_if, des_key_sched, des_round.
`include "des_block_cipher_unit_assert.svh"
module des_block_cipher_unit import des_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  block_t   cfg_wdata,
  des_in_if.sink   in_ch,
  des_out_if.source out_ch
);
  subkey_t [NumRounds-1:0] round_keys;
  logic                    advance;
  logic                    stg_valid [NumRounds+1];
  round_data_t             stg_data [NumRounds+1];
  logic                    in_valid_r;
  round_data_t             in_data_r;
  logic                    out_valid_r;
  block_t                  out_block_r;

  des_key_sched u_key (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .round_keys
  );

  // Whole pipeline moves together; stall only when the output is held.
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      in_valid_r  <= in_ch.valid;
      out_valid_r <= stg_valid[NumRounds];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      in_data_r.dec <= in_ch.action;
      {in_data_r.l, in_data_r.r} <= perm_ip(in_ch.data_block);
      out_block_r <= perm_fp({stg_data[NumRounds].r, stg_data[NumRounds].l});
    end
  end

  assign stg_valid[0] = in_valid_r;
  assign stg_data[0]  = in_data_r;

  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    des_round u_round (
      .clk, .rst_n, .advance,
      .in_valid  (stg_valid[g]),
      .in_data   (stg_data[g]),
      .round_keys,
      .round_idx (4'(g)),
      .out_valid (stg_valid[g+1]),
      .out_data  (stg_data[g+1])
    );
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_block = out_block_r;

  `DES_ASSERT_NEXT(a_hold_out, clk, rst_n, out_valid_r && !out_ch.ready, out_valid_r && $stable(out_block_r), "result dropped while stalled")
  `DES_ASSERT_NOW(a_ready, clk, rst_n, !out_valid_r, in_ch.ready, "input blocked with empty output")
  `DES_ASSERT_NEXT(a_move, clk, rst_n, advance && stg_valid[NumRounds], out_valid_r, "last round lost")
endmodule

// File: dv/des_tb_if.sv
`timescale 1ns / 100ps
// Testbench-side notes: the block's channel interfaces live in the RTL tree
// (des_in_if, des_out_if); this file holds the cycle watchdog interface.
// Depends on nothing.
interface des_tb_watch_if (input logic clk);
  int unsigned idle_cycles;
endinterface

// File: dv/tb.sv
`timescale 1ns / 100ps
// Testbench for des_block_cipher_unit: random and directed DES ECB blocks
// checked against an in-bench DES predictor over several keys.
// Depends on des_pkg, des_in_if, des_out_if, des_tb_watch_if and the DUT RTL.
module tb;
  import des_pkg::*;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 40;

  typedef struct packed {
    logic   action;
    block_t data_block;
  } des_item_t;

  class cipher_scoreboard;
    block_t result_q[$];
    logic [47:0] subkeys[16];
    int unsigned errors;

    function new();
      errors = 0;
      set_key('0);
    endfunction

    function automatic logic [63:0] bitsel(logic [63:0] src, int w, byte unsigned tab[],
                                           int n);
      logic [63:0] o;
      o = '0;
      for (int i = 0; i < n; i++) o = {o[62:0], src[w - int'(tab[i])]};
      return o;
    endfunction

    function void set_key(block_t key);
      byte unsigned t_pc1[] = TabPc1;
      byte unsigned t_pc2[] = TabPc2;
      logic [55:0] cd;
      logic [27:0] c, d;
      cd = 56'(bitsel(key, 64, t_pc1, 56));
      c = cd[55:28];
      d = cd[27:0];
      for (int r = 0; r < 16; r++) begin
        for (int j = 0; j < int'(TabRot[r]); j++) begin
          c = {c[26:0], c[27]};
          d = {d[26:0], d[27]};
        end
        subkeys[r] = 48'(bitsel(64'({c, d}), 56, t_pc2, 48));
      end
    endfunction

    function logic [31:0] round_mix(logic [31:0] r, logic [47:0] k);
      byte unsigned t_e[] = TabE;
      byte unsigned t_p[] = TabP;
      logic [47:0] x;
      logic [31:0] s;
      logic [5:0] six;
      x = 48'(bitsel(64'(r), 32, t_e, 48)) ^ k;
      s = '0;
      for (int i = 0; i < 8; i++) begin
        six = x[47-6*i -: 6];
        s = {s[27:0], TabS[i][16*{six[5], six[0]} + six[4:1]][3:0]};
      end
      return 32'(bitsel(64'(s), 32, t_p, 32));
    endfunction

    function void note_input(des_item_t it);
      byte unsigned t_ip[] = TabIp;
      byte unsigned t_fp[] = TabFp;
      logic [63:0] b;
      logic [31:0] l, r, t;
      b = bitsel(it.data_block, 64, t_ip, 64);
      l = b[63:32];
      r = b[31:0];
      for (int i = 0; i < 16; i++) begin
        t = r;
        r = l ^ round_mix(r, subkeys[(it.action == ActDecrypt) ? 15 - i : i]);
        l = t;
      end
      result_q.push_back(bitsel({r, l}, 64, t_fp, 64));
    endfunction

    function void check_result(block_t got);
      block_t want;
      if (result_q.size() == 0) begin
        $error("result_block: unexpected transaction, actual %h", got);
        errors++;
        return;
      end
      want = result_q.pop_front();
      if (got !== want) begin
        $error("result_block: expected %h actual %h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  block_t cfg_wdata;
  bit stall_en;

  des_in_if  in_ch ();
  des_out_if out_ch ();
  des_tb_watch_if u_watch (.clk(clk));
  cipher_scoreboard sb;

  des_block_cipher_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_input({in_ch.action, in_ch.data_block});
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.result_block);
    end
  end

  always @(posedge clk) begin
    int unsigned ph;
    ph = $urandom_range(0, 15);
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (!stall_en) out_ch.ready <= 1'b1;
    else out_ch.ready <= (ph > 4) || ($urandom_range(0, 1) == 0 && ph > 1);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      u_watch.idle_cycles <= 0;
    else u_watch.idle_cycles <= u_watch.idle_cycles + 1;
    if (u_watch.idle_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_block(logic act, block_t blk, bit keep);
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.data_block <= blk;
    do @(posedge clk); while (!in_ch.ready);
    if (!keep) in_ch.valid <= 1'b0;
  endtask

  task automatic send_burst(int n);
    int gap;
    for (int i = 0; i < n; i++) begin
      send_block(1'($urandom), {$urandom, $urandom}, i != n - 1);
    end
    gap = $urandom_range(1, 6);
    repeat (gap) @(posedge clk);
  endtask

  task automatic drain();
    while (sb.result_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_key(block_t key);
    cfg_we <= 1'b1;
    cfg_wdata <= key;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_key(key);
    @(posedge clk);
  endtask

  initial begin
    block_t keys[6];
    block_t edge_blk[6];
    int sent;
    int n;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ActEncrypt;
    in_ch.data_block = '0;
    sb = new();
    stall_en = 1'b0;
    keys[0] = 64'h1334_5779_9BBC_DFF1;
    keys[1] = 64'hFFFF_FFFF_FFFF_FFFF;
    keys[2] = 64'h0101_0101_0101_0101;
    keys[3] = {$urandom, $urandom};
    keys[4] = 64'hFEFE_FEFE_FEFE_FEFE;
    keys[5] = {$urandom, $urandom};
    edge_blk = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF,
                 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001, 64'hAAAA_5555_AAAA_5555};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < 6; i++) send_block(ActEncrypt, edge_blk[i], i != 5);
    drain();
    write_key(keys[0]);
    for (int i = 0; i < 6; i++) begin
      send_block(ActEncrypt, edge_blk[i], 1'b1);
      send_block(ActDecrypt, edge_blk[i], i != 5);
    end
    drain();
    stall_en = 1'b1;
    sent = 0;
    for (int k = 1; k < 6; k++) begin
      write_key(keys[k]);
      stall_en = (k != 2);
      for (int j = 0; j < 160; j += n) begin
        n = $urandom_range(1, 12);
        send_burst(n);
        sent += n;
        if (sent > 300 && sent < 320) begin
          while (sb.result_q.size() != 0) @(posedge clk);
          sent = 400;
        end
      end
      drain();
    end
    write_key('0);
    send_burst(20);
    drain();
    if (sb.errors == 0 && sb.result_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
